// ===== sv/mmpq_pkg.sv =====
// Shared types and constants for the min/max priority queue.
package mmpq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = 5;
  localparam int DATA_W = 32;

  localparam logic [OCC_W-1:0] DEPTH_CNT = OCC_W'(DEPTH);

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic CFG_ORDER_MODE = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    status_t            status;
    logic [OCC_W-1:0]   occupancy_now;
  } out_rsp_t;

  typedef struct packed {
    logic             order_mode;
    logic [OCC_W-1:0] capacity_limit;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

endpackage

// ===== sv/mmpq_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
module mmpq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/mmpq_ctrl.sv =====
// Sequencer that appends, scans for the best entry and compacts the entry memory.
module mmpq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  mmpq_pkg::in_req_t             in_req,
  input  mmpq_pkg::cfg_t                cfg,
  input  logic [mmpq_pkg::DATA_W-1:0]   mem_rdata,
  output mmpq_pkg::mem_req_t            mem_req,
  output logic                          busy,
  output logic                          out_valid,
  output mmpq_pkg::out_rsp_t            out_rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [mmpq_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  logic [mmpq_pkg::OCC_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [mmpq_pkg::ADDR_W-1:0]      rd_tag_r, rd_tag_nxt;
  logic [mmpq_pkg::DATA_W-1:0]      best_r, best_nxt;
  logic [mmpq_pkg::ADDR_W-1:0]      pick_r, pick_nxt;
  logic                             out_valid_r, out_valid_nxt;
  mmpq_pkg::out_rsp_t               out_rsp_r, out_rsp_nxt;

  logic [mmpq_pkg::OCC_W-1:0]       limit;
  logic [mmpq_pkg::OCC_W-1:0]       occ_last;
  logic                             better;
  logic [mmpq_pkg::ADDR_W-1:0]      sel_pick;
  logic [mmpq_pkg::DATA_W-1:0]      sel_best;

  always_comb begin
    limit = (cfg.capacity_limit < mmpq_pkg::DEPTH_CNT) ? cfg.capacity_limit
                                                       : mmpq_pkg::DEPTH_CNT;
    occ_last = occ_r - 1'b1;
    if (rd_tag_r == '0) begin
      better = 1'b1;
    end else if (cfg.order_mode) begin
      better = $signed(mem_rdata) > $signed(best_r);
    end else begin
      better = $signed(mem_rdata) < $signed(best_r);
    end
    sel_pick = better ? rd_tag_r : pick_r;
    sel_best = better ? mem_rdata : best_r;
  end

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_tag_nxt    = rd_tag_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req.opcode == mmpq_pkg::OP_ENQUEUE) begin
            out_valid_nxt         = 1'b1;
            out_rsp_nxt.out_value = '0;
            if (occ_r >= limit) begin
              out_rsp_nxt.status        = mmpq_pkg::STATUS_FULL;
              out_rsp_nxt.occupancy_now = occ_r;
            end else begin
              mem_req.wr_en             = 1'b1;
              mem_req.wr_addr           = occ_r[mmpq_pkg::ADDR_W-1:0];
              mem_req.wr_data           = in_req.item_value;
              occ_nxt                   = occ_r + 1'b1;
              out_rsp_nxt.status        = mmpq_pkg::STATUS_OK;
              out_rsp_nxt.occupancy_now = occ_r + 1'b1;
            end
          end else if (occ_r == '0) begin
            out_valid_nxt             = 1'b1;
            out_rsp_nxt.out_value     = -32'sd1;
            out_rsp_nxt.status        = mmpq_pkg::STATUS_EMPTY;
            out_rsp_nxt.occupancy_now = '0;
          end else begin
            state_nxt  = ST_SCAN;
            rd_ptr_nxt = '0;
          end
        end
      end

      ST_SCAN: begin
        if (rd_ptr_r < occ_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_ptr_r[mmpq_pkg::ADDR_W-1:0];
          rd_vld_nxt      = 1'b1;
          rd_tag_nxt      = rd_ptr_r[mmpq_pkg::ADDR_W-1:0];
          rd_ptr_nxt      = rd_ptr_r + 1'b1;
        end
        if (rd_vld_r) begin
          pick_nxt = sel_pick;
          best_nxt = sel_best;
          if ({1'b0, rd_tag_r} == occ_last) begin
            state_nxt  = ST_COMPACT;
            rd_ptr_nxt = {1'b0, sel_pick} + 1'b1;
          end
        end
      end

      ST_COMPACT: begin
        if (rd_ptr_r < occ_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_ptr_r[mmpq_pkg::ADDR_W-1:0];
          rd_vld_nxt      = 1'b1;
          rd_tag_nxt      = rd_ptr_r[mmpq_pkg::ADDR_W-1:0];
          rd_ptr_nxt      = rd_ptr_r + 1'b1;
        end
        if (rd_vld_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = rd_tag_r - 1'b1;
          mem_req.wr_data = mem_rdata;
        end
        if (rd_ptr_r >= occ_r && !rd_vld_r) begin
          state_nxt                 = ST_IDLE;
          occ_nxt                   = occ_last;
          out_valid_nxt             = 1'b1;
          out_rsp_nxt.out_value     = best_r;
          out_rsp_nxt.status        = mmpq_pkg::STATUS_OK;
          out_rsp_nxt.occupancy_now = occ_last;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      rd_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_tag_r  <= rd_tag_nxt;
    best_r    <= best_nxt;
    pick_r    <= pick_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== sv/min_max_priority_queue_top.sv =====
// Top level of the min/max priority queue: configuration registers, memory and sequencer.
//
// A request is taken when start is high and busy is low; each request gives exactly one
// result, shown on out_rsp for one cycle with out_valid high, and the receiver must take
// it then. An enqueue, accepted or refused, never raises busy and its result appears on
// the next cycle, so enqueues can be issued every cycle. A dequeue on an empty queue
// behaves the same way. A dequeue on a non-empty queue holds busy high while it scans for
// the best entry and moves the later entries down, and its result appears in the first
// cycle with busy low. How long it stays busy depends on the occupancy and on where the
// served entry sits; it is set by the single read port of the entry memory, which reads
// one entry per cycle to find the best entry and again to move the later entries down.
// Configuration writes must be made while no request is outstanding.
module min_max_priority_queue_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  mmpq_pkg::in_req_t              in_req,
  output logic                           out_valid,
  output mmpq_pkg::out_rsp_t             out_rsp,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mmpq_pkg::OCC_W-1:0]     cfg_wdata
);

  mmpq_pkg::cfg_t                  cfg_r;
  mmpq_pkg::mem_req_t              mem_req;
  logic [mmpq_pkg::DATA_W-1:0]     mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.order_mode     <= 1'b0;
      cfg_r.capacity_limit <= mmpq_pkg::DEPTH_CNT;
    end else if (cfg_we) begin
      case (cfg_index)
        mmpq_pkg::CFG_ORDER_MODE: cfg_r.order_mode     <= cfg_wdata[0];
        mmpq_pkg::CFG_CAPACITY:   cfg_r.capacity_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mmpq_ram #(
    .WIDTH (mmpq_pkg::DATA_W),
    .DEPTH (mmpq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data)
  );

  mmpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .cfg       (cfg_r),
    .mem_rdata (mem_rdata),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a dequeue is still running");

  a_enqueue_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.opcode == mmpq_pkg::OP_ENQUEUE) |=> (out_valid && !busy))
    else $error("enqueue did not complete in one cycle");

  a_dequeue_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.opcode == mmpq_pkg::OP_DEQUEUE) |=> (busy || out_valid))
    else $error("dequeue request was lost");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == mmpq_pkg::STATUS_EMPTY) |-> (out_rsp.occupancy_now == '0))
    else $error("empty status with entries held");

endmodule

// ===== dv/min_max_priority_queue_top_test.sv =====
// Self-checking testbench for the min/max priority queue with a scoreboard class.
class pq_scoreboard;
  logic signed [31:0]     held_vals [mmpq_pkg::DEPTH];
  int                     held_cnt;
  logic                   serve_max;
  logic [mmpq_pkg::OCC_W-1:0] cap_lim;
  mmpq_pkg::out_rsp_t     pending_rsp [$];
  int                     mismatches;

  function new();
    held_cnt   = 0;
    serve_max  = 1'b0;
    cap_lim    = mmpq_pkg::DEPTH_CNT;
    mismatches = 0;
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function void write_reg(logic idx, logic [mmpq_pkg::OCC_W-1:0] val);
    if (idx == mmpq_pkg::CFG_ORDER_MODE) serve_max = val[0];
    else cap_lim = val;
  endfunction

  function int pending();
    return pending_rsp.size();
  endfunction

  function void take_request(mmpq_pkg::in_req_t r);
    mmpq_pkg::out_rsp_t exp;
    int                 lim;
    int                 pick;
    exp.out_value = 32'sd0;
    exp.status    = mmpq_pkg::STATUS_OK;
    if (r.opcode == mmpq_pkg::OP_ENQUEUE) begin
      lim = (cap_lim < mmpq_pkg::DEPTH) ? int'(cap_lim) : mmpq_pkg::DEPTH;
      if (held_cnt >= lim) begin
        exp.status = mmpq_pkg::STATUS_FULL;
      end else begin
        held_vals[held_cnt] = r.item_value;
        held_cnt++;
      end
    end else if (held_cnt == 0) begin
      exp.out_value = -32'sd1;
      exp.status    = mmpq_pkg::STATUS_EMPTY;
    end else begin
      pick = 0;
      for (int i = 1; i < held_cnt; i++) begin
        if (serve_max ? (held_vals[i] > held_vals[pick]) : (held_vals[i] < held_vals[pick]))
          pick = i;
      end
      exp.out_value = held_vals[pick];
      for (int i = pick; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i+1];
      held_cnt--;
    end
    exp.occupancy_now = held_cnt[mmpq_pkg::OCC_W-1:0];
    pending_rsp.push_back(exp);
  endfunction

  task check_response(mmpq_pkg::out_rsp_t got);
    mmpq_pkg::out_rsp_t exp;
    if (pending_rsp.size() == 0) begin
      report($sformatf("unexpected result value=%h status=%0d occ=%0d",
                       got.out_value, got.status, got.occupancy_now));
    end else begin
      exp = pending_rsp.pop_front();
      if (got.out_value !== exp.out_value)
        report($sformatf("out_value got %h expected %h", got.out_value, exp.out_value));
      if (got.status !== exp.status)
        report($sformatf("status got %0d expected %0d", got.status, exp.status));
      if (got.occupancy_now !== exp.occupancy_now)
        report($sformatf("occupancy_now got %0d expected %0d",
                         got.occupancy_now, exp.occupancy_now));
    end
  endtask
endclass

module min_max_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_MIN_FIRST = 1'b0;
  localparam logic MODE_MAX_FIRST = 1'b1;
  localparam int   CYCLE_LIMIT    = 200000;
  localparam int   PHASES         = 8;
  localparam int   PHASE_ITEMS    = 66;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  mmpq_pkg::in_req_t          in_req;
  logic                       out_valid;
  mmpq_pkg::out_rsp_t         out_rsp;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [mmpq_pkg::OCC_W-1:0] cfg_wdata;

  pq_scoreboard sb;
  int           cycles;

  min_max_priority_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && sb != null) sb.check_response(out_rsp);
  end

  function automatic mmpq_pkg::in_req_t make_req(logic op, logic signed [31:0] val);
    mmpq_pkg::in_req_t r;
    r.opcode     = op;
    r.item_value = val;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5:    return 32'(int'($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic drop_start(int n);
    repeat (n) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= make_req(1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic send_req(mmpq_pkg::in_req_t r);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sb.take_request(r);
  endtask

  task automatic drain();
    drop_start(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [mmpq_pkg::OCC_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= mmpq_pkg::OCC_W'($urandom);
  endtask

  task automatic set_mode(logic mode);
    write_reg(mmpq_pkg::CFG_ORDER_MODE, {4'($urandom), mode});
  endtask

  logic                       phase_mode [PHASES] = '{MODE_MIN_FIRST, MODE_MAX_FIRST,
                                                      MODE_MIN_FIRST, MODE_MAX_FIRST,
                                                      MODE_MIN_FIRST, MODE_MAX_FIRST,
                                                      MODE_MIN_FIRST, MODE_MAX_FIRST};
  logic [mmpq_pkg::OCC_W-1:0] phase_cap  [PHASES] = '{5'd1, 5'd16, 5'd31, 5'd3, 5'd17,
                                                      5'd0, 5'd8, 5'd16};

  initial begin
    int enq_pct;
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_index = mmpq_pkg::CFG_ORDER_MODE;
    cfg_wdata = '0;
    cycles    = 0;
    sb        = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_req(make_req(mmpq_pkg::OP_DEQUEUE, $urandom));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, 32'sh7fff_ffff));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, 32'sh8000_0000));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, -32'sd1));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, 32'sd0));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, 32'sd5));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, 32'sd5));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, -32'sd5));
    repeat (9) send_req(make_req(mmpq_pkg::OP_ENQUEUE, $urandom));
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, $urandom));
    repeat (3) send_req(make_req(mmpq_pkg::OP_DEQUEUE, $urandom));
    drain();
    set_mode(MODE_MAX_FIRST);
    repeat (2) send_req(make_req(mmpq_pkg::OP_DEQUEUE, $urandom));
    drain();
    write_reg(mmpq_pkg::CFG_CAPACITY, 5'd0);
    send_req(make_req(mmpq_pkg::OP_ENQUEUE, $urandom));
    drain();
    write_reg(mmpq_pkg::CFG_CAPACITY, 5'd16);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_mode(phase_mode[p]);
      write_reg(mmpq_pkg::CFG_CAPACITY, phase_cap[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        enq_pct = (k < PHASE_ITEMS / 2) ? 70 : 35;
        if (p < PHASES - 1 && $urandom_range(0, 3) == 0) drop_start($urandom_range(1, 3));
        if ($urandom_range(0, 99) < enq_pct)
          send_req(make_req(mmpq_pkg::OP_ENQUEUE, pick_value()));
        else send_req(make_req(mmpq_pkg::OP_DEQUEUE, $urandom));
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/mmpq_pkg.sv
sv/mmpq_ram.sv
sv/mmpq_ctrl.sv
sv/min_max_priority_queue_top.sv
dv/min_max_priority_queue_top_test.sv
